FILE: hdl/rhsv_pkg.sv
// constants, types and the division step shared by the rgb to hsv pipeline
`default_nettype none

package rhsv_pkg;

    localparam int unsigned ChW           = 8;
    localparam int unsigned RemW          = 2 * ChW;
    localparam int unsigned HueProdW      = 14;
    localparam int unsigned QuoW          = ChW;
    localparam int unsigned StepsPerStage = 2;
    localparam int unsigned DivStages     = QuoW / StepsPerStage;

    localparam logic [ChW-1:0] HueBaseRed   = 8'd0;
    localparam logic [ChW-1:0] HueBaseGreen = 8'd85;
    localparam logic [ChW-1:0] HueBaseBlue  = 8'd171;
    localparam logic [5:0]     HueScale     = 6'd43;

    // one item as it moves through the shared long-division stages
    typedef struct packed {
        logic [RemW-1:0]     sat_rem;
        logic [ChW-1:0]      sat_div;
        logic [QuoW-1:0]     sat_q;
        logic [HueProdW-1:0] hue_rem;
        logic [ChW-1:0]      hue_div;
        logic [QuoW-1:0]     hue_q;
        logic [ChW-1:0]      base;
        logic                neg;
        logic [ChW-1:0]      value;
    } t_div;

    // one restoring division step for both quotients at quotient bit qbit
    function automatic t_div div_step(input t_div d, input int unsigned qbit);
        t_div            r;
        logic [RemW-1:0] sat_sh;
        logic [RemW-1:0] hue_sh;
        logic [RemW-1:0] hue_ext;
        r       = d;
        sat_sh  = {{(RemW-ChW){1'b0}}, d.sat_div} << qbit;
        hue_sh  = {{(RemW-ChW){1'b0}}, d.hue_div} << qbit;
        hue_ext = {{(RemW-HueProdW){1'b0}}, d.hue_rem};
        if (d.sat_rem >= sat_sh) begin
            r.sat_rem = d.sat_rem - sat_sh;
            r.sat_q[qbit[2:0]] = 1'b1;
        end
        if (hue_ext >= hue_sh) begin
            r.hue_rem = HueProdW'(hue_ext - hue_sh);
            r.hue_q[qbit[2:0]] = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb_to_hsv_pixel.sv
// rgb to hsv pixel converter, pipelined, one pixel per clock while the output is not stalled
//
// input channel: i_valid / o_ready with i_red, i_green, i_blue (8 bits each)
// output channel: o_valid / i_ready with o_hue, o_saturation, o_brightness
// brightness is the largest channel; saturation is 255*(max-min)/max and hue
// is 0, 85 or 171 plus 43*diff/(max-min), truncated toward zero, mod 256
// from input transfer to output valid the pixel passes 7 register stages,
// the first loaded at the transfer edge itself:
//   stage 1 max/min and channel difference, stage 2 the two constant
//   multiplies, stages 3..6 two quotient bits per stage for both divisions,
//   stage 7 hue/saturation fixup into the output register
// throughput is one pixel per clock while i_ready is high, as the divider is fully pipelined
// all stages advance together; when the receiver holds i_ready low with a
// result waiting, the whole pipeline holds and o_ready drops, nothing lost
// reset clears every valid bit; data registers are not reset
`default_nettype none

module rgb_to_hsv_pixel (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [rhsv_pkg::ChW-1:0] i_red,
    input  wire logic [rhsv_pkg::ChW-1:0] i_green,
    input  wire logic [rhsv_pkg::ChW-1:0] i_blue,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [rhsv_pkg::ChW-1:0]     o_hue,
    output logic [rhsv_pkg::ChW-1:0]     o_saturation,
    output logic [rhsv_pkg::ChW-1:0]     o_brightness
);

    localparam int unsigned ChW       = rhsv_pkg::ChW;
    localparam int unsigned DivStages = rhsv_pkg::DivStages;
    localparam int unsigned HueProdW  = rhsv_pkg::HueProdW;

    logic w_en;

    // stage 1 registers
    logic           r_s1_valid;
    logic [ChW-1:0] r_s1_value;
    logic [ChW-1:0] r_s1_span;
    logic [ChW-1:0] r_s1_base;
    logic           r_s1_neg;
    logic [ChW-1:0] r_s1_mag;

    logic [ChW-1:0] n_s1_value;
    logic [ChW-1:0] n_s1_min;
    logic [ChW-1:0] n_s1_base;
    logic [ChW-1:0] n_s1_a;
    logic [ChW-1:0] n_s1_b;

    // division pipeline: entry 0 is written by the multiply stage
    rhsv_pkg::t_div r_div   [0:DivStages];
    logic           r_dvalid[0:DivStages];
    rhsv_pkg::t_div n_div0;

    // output stage
    logic           r_out_valid;
    logic [ChW-1:0] r_hue;
    logic [ChW-1:0] r_sat;
    logic [ChW-1:0] r_val;
    logic [ChW-1:0] n_sat;
    logic [ChW-1:0] n_hue;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // stage 1: max, min, base and signed difference of the other two
    always_comb begin
        n_s1_value = i_red;
        if (i_green > n_s1_value) n_s1_value = i_green;
        if (i_blue > n_s1_value) n_s1_value = i_blue;
        n_s1_min = i_red;
        if (i_green < n_s1_min) n_s1_min = i_green;
        if (i_blue < n_s1_min) n_s1_min = i_blue;
        // red wins a tie, then green
        if (n_s1_value == i_red) begin
            n_s1_base = rhsv_pkg::HueBaseRed;
            n_s1_a    = i_green;
            n_s1_b    = i_blue;
        end else if (n_s1_value == i_green) begin
            n_s1_base = rhsv_pkg::HueBaseGreen;
            n_s1_a    = i_blue;
            n_s1_b    = i_red;
        end else begin
            n_s1_base = rhsv_pkg::HueBaseBlue;
            n_s1_a    = i_red;
            n_s1_b    = i_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_value <= n_s1_value;
            r_s1_span  <= n_s1_value - n_s1_min;
            r_s1_base  <= n_s1_base;
            r_s1_neg   <= (n_s1_a < n_s1_b);
            r_s1_mag   <= (n_s1_a < n_s1_b) ? (n_s1_b - n_s1_a) : (n_s1_a - n_s1_b);
        end
    end

    // stage 2: 255*span and 43*|diff|
    always_comb begin
        n_div0         = '0;
        n_div0.sat_rem = {r_s1_span, {ChW{1'b0}}} - {{ChW{1'b0}}, r_s1_span};
        n_div0.sat_div = r_s1_value;
        n_div0.hue_rem = HueProdW'(rhsv_pkg::HueScale) * HueProdW'(r_s1_mag);
        n_div0.hue_div = r_s1_span;
        n_div0.base    = r_s1_base;
        n_div0.neg     = r_s1_neg;
        n_div0.value   = r_s1_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid[0] <= 1'b0;
        end else if (w_en) begin
            r_dvalid[0] <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div[0] <= n_div0;
        end
    end

    // stages 3..6: two quotient bits per stage, msb first
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        rhsv_pkg::t_div n_div;

        always_comb begin
            n_div = r_div[k];
            for (int j = 0; j < rhsv_pkg::StepsPerStage; j++) begin
                n_div = rhsv_pkg::div_step(n_div,
                    rhsv_pkg::QuoW - 1 - k * rhsv_pkg::StepsPerStage - j);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvalid[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dvalid[k+1] <= r_dvalid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[k+1] <= n_div;
            end
        end
    end

    // stage 7: black and gray pixels, signed hue term, wrap mod 256
    always_comb begin
        n_sat = (r_div[DivStages].value == '0) ? '0 : r_div[DivStages].sat_q;
        if (n_sat == '0) begin
            n_hue = '0;
        end else if (r_div[DivStages].neg) begin
            n_hue = r_div[DivStages].base - r_div[DivStages].hue_q;
        end else begin
            n_hue = r_div[DivStages].base + r_div[DivStages].hue_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dvalid[DivStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= r_div[DivStages].value;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_val;

endmodule

`default_nettype wire
